// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules of the radix ascii converter
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled while reset is low
`define ITRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold at a clock edge
`define ITRA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/itra_pkg.sv =====
// shared constants, types and the digit-to-ascii function
// of the integer to radix ascii converter; no dependencies
package itra_pkg;

    // width of the formatted integer and of the input port
    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;

    // divider: quotient bits retired per cycle and stepping cycles per digit
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_WIDTH  = DIV_CYCLES * DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    // digit store: radix 2 gives at most one digit per value bit
    localparam int DIGIT_DEPTH  = VALUE_WIDTH;
    localparam int DIGIT_ADDR_W = $clog2(DIGIT_DEPTH);

    // field widths
    localparam int RADIX_W    = 6;
    localparam int FLAGS_W    = 2;
    localparam int LEN_W      = 7;
    localparam int CHAR_W     = 7;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // format flag bits
    localparam int FLAG_PLUS  = 0;
    localparam int FLAG_UPPER = 1;

    // register limits and reset values
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [FLAGS_W-1:0] FLAGS_RESET   = 2'd0;
    localparam logic [LEN_W-1:0]   MAX_LEN_LIMIT = 7'd64;
    localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 7'd64;

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_PLUS     = 7'd43;
    localparam logic [CHAR_W-1:0] ASCII_MINUS    = 7'd45;
    localparam logic [CHAR_W-1:0] ASCII_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A  = 7'd65;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A  = 7'd97;
    localparam logic [CHAR_W-1:0] ASCII_NUL      = 7'd0;
    localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;

    // result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TOO_LONG = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX   = 2'd0,
        CFG_FORMAT  = 2'd1,
        CFG_MAX_LEN = 2'd2
    } t_cfg_index;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_EMIT
    } t_ctrl_state;

    // digit store write port
    typedef struct packed {
        logic                    en;
        logic [DIGIT_ADDR_W-1:0] addr;
        logic [RADIX_W-1:0]      digit;
    } t_digit_wr;

    // emission command from the sequencer
    typedef struct packed {
        logic             start;
        logic             err;
        logic             neg;
        logic             upper;
        logic [LEN_W-1:0] ndig;
        logic [LEN_W-1:0] total;
    } t_emit_cmd;

    // digit value 0..35 to its ascii character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] d7;
        d7 = CHAR_W'(d);
        if (d < DECIMAL_DIGITS) begin
            return ASCII_ZERO + d7;
        end else if (upper) begin
            return ASCII_UPPER_A + d7 - CHAR_W'(DECIMAL_DIGITS);
        end else begin
            return ASCII_LOWER_A + d7 - CHAR_W'(DECIMAL_DIGITS);
        end
    endfunction

endpackage

// ===== rtl/itra_if.sv =====
// valid/ready channel interfaces of the converter: input, result and config
// depends on itra_pkg
interface itra_in_if import itra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IN_WIDTH-1:0] value;
    logic                is_signed;

    modport source (output valid, value, is_signed, input ready);
    modport sink   (input valid, value, is_signed, output ready);
endinterface

interface itra_out_if import itra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  total_length;
    logic              status;
    logic              last;

    modport source (output valid, character, position, total_length, status, last,
                    input ready);
    modport sink   (input valid, character, position, total_length, status, last,
                    output ready);
endinterface

interface itra_cfg_if import itra_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/integer_to_radix_ascii_unit.sv =====
// top level of the integer to radix ascii converter: config registers and sequencer
// depends on itra_pkg, itra_if, itra_divider and itra_emitter
//
// channel  dir  handshake    payload
// i_cfg    in   valid/ready  index[1:0], data[6:0]
// i_in     in   valid/ready  value[63:0], is_signed
// o_out    out  valid/ready  character[6:0], position[5:0], total_length[6:0], status, last
//
// each digit is produced by the divider, which retires DIV_STEPS quotient bits per cycle;
// then come the check state, a read stage and the output register, which passes one
// character per cycle while the result channel is not stalled.
// reset is synchronous, active low; the digit store needs no clearing pass.
// a stalled result holds in the output register; the next item is taken once the last
// character of the previous one has left the digit store.

module integer_to_radix_ascii_unit import itra_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itra_cfg_if.sink   i_cfg,
    itra_in_if.sink    i_in,
    itra_out_if.source o_out
);

    // configuration registers
    logic [RADIX_W-1:0] r_radix;
    logic [FLAGS_W-1:0] r_flags;
    logic [LEN_W-1:0]   r_max_len;

    // sequencer state
    t_ctrl_state        r_state, n_state;
    logic [LEN_W-1:0]   r_ndig, n_ndig;
    logic               r_neg, n_neg;
    logic               r_plus, n_plus;
    logic               r_upper, n_upper;
    logic [RADIX_W-1:0] r_div_radix, n_div_radix;
    logic [LEN_W-1:0]   r_cap, n_cap;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] in_bits;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [RADIX_W-1:0]     radix_eff;
    logic [LEN_W-1:0]       cap_eff;
    logic [LEN_W-1:0]       total;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [RADIX_W-1:0]     div_radix;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [RADIX_W-1:0]     div_remainder;

    t_digit_wr digit_wr;
    t_emit_cmd emit_cmd;
    logic      emit_busy;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix   <= RADIX_RESET;
            r_flags   <= FLAGS_RESET;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_index'(i_cfg.index))
                CFG_RADIX:   r_radix   <= i_cfg.data[RADIX_W-1:0];
                CFG_FORMAT:  r_flags   <= i_cfg.data[FLAGS_W-1:0];
                CFG_MAX_LEN: r_max_len <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // input decode: magnitude and sign, clamped radix and capacity
    always_comb begin
        in_bits = i_in.value[VALUE_WIDTH-1:0];
        in_neg  = i_in.is_signed && in_bits[VALUE_WIDTH-1];
        in_mag  = in_neg ? (VALUE_WIDTH'(0) - in_bits) : in_bits;
        if (r_radix < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = r_radix;
        end
        cap_eff = (r_max_len > MAX_LEN_LIMIT) ? MAX_LEN_LIMIT : r_max_len;
        total   = r_ndig + LEN_W'(r_neg || r_plus);
    end

    // sequencer next state and outputs
    always_comb begin
        n_state      = r_state;
        n_ndig       = r_ndig;
        n_neg        = r_neg;
        n_plus       = r_plus;
        n_upper      = r_upper;
        n_div_radix  = r_div_radix;
        n_cap        = r_cap;
        i_in.ready   = 1'b0;
        accept       = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_quotient;
        div_radix    = r_div_radix;
        digit_wr     = '0;
        emit_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                accept     = i_in.valid;
                if (accept) begin
                    n_neg        = in_neg;
                    n_plus       = r_flags[FLAG_PLUS];
                    n_upper      = r_flags[FLAG_UPPER];
                    n_div_radix  = radix_eff;
                    n_cap        = cap_eff;
                    n_ndig       = '0;
                    div_start    = 1'b1;
                    div_dividend = in_mag;
                    div_radix    = radix_eff;
                    n_state      = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    digit_wr.en    = 1'b1;
                    digit_wr.addr  = r_ndig[DIGIT_ADDR_W-1:0];
                    digit_wr.digit = div_remainder;
                    n_ndig         = r_ndig + LEN_W'(1);
                    if (div_quotient == '0) begin
                        n_state = ST_CHECK;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                emit_cmd.start = 1'b1;
                emit_cmd.err   = (total > r_cap);
                emit_cmd.neg   = r_neg;
                emit_cmd.upper = r_upper;
                emit_cmd.ndig  = r_ndig;
                emit_cmd.total = total;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ndig  <= '0;
        end else begin
            r_state <= n_state;
            r_ndig  <= n_ndig;
        end
    end

    // per-item format registers
    always_ff @(posedge i_clk) begin
        r_neg       <= n_neg;
        r_plus      <= n_plus;
        r_upper     <= n_upper;
        r_div_radix <= n_div_radix;
        r_cap       <= n_cap;
    end

    itra_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_radix     (div_radix),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    itra_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (digit_wr),
        .i_cmd   (emit_cmd),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/itra_divider.sv =====
// digit-serial restoring divider: value by radix, DIV_STEPS quotient bits per cycle
// depends on itra_pkg and assert_macros.svh
`include "assert_macros.svh"

module itra_divider import itra_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [RADIX_W-1:0]     i_radix,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [RADIX_W-1:0]     o_remainder
);

    logic [DIV_WIDTH-1:0] r_quo, n_quo;
    logic [RADIX_W-1:0]   r_rem, n_rem;
    logic [RADIX_W-1:0]   r_radix, n_radix;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;

    // load on start, otherwise shift DIV_STEPS dividend bits through the remainder
    always_comb begin
        logic [RADIX_W:0]     part;
        logic [RADIX_W-1:0]   rem;
        logic [DIV_STEPS-1:0] qbits;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_radix = r_radix;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        part    = '0;
        rem     = r_rem;
        qbits   = '0;
        if (i_start) begin
            n_quo   = DIV_WIDTH'(i_dividend);
            n_rem   = '0;
            n_radix = i_radix;
            n_cnt   = DIV_CNT_W'(DIV_CYCLES);
        end else if (r_cnt != '0) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                part = {rem, r_quo[DIV_WIDTH-1-k]};
                if (part >= {1'b0, r_radix}) begin
                    part                 = part - {1'b0, r_radix};
                    qbits[DIV_STEPS-1-k] = 1'b1;
                end
                rem = part[RADIX_W-1:0];
            end
            n_quo  = (r_quo << DIV_STEPS) | DIV_WIDTH'(qbits);
            n_rem  = rem;
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            n_done = (r_cnt == DIV_CNT_W'(1));
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_radix <= n_radix;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo[VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

    // checks
    `ITRA_ASSERT(a_rem_below_radix, i_clk, i_rst_n,
        r_done |-> (r_rem < r_radix), "digit not below radix")
    `ITRA_ASSERT(a_start_only_when_free, i_clk, i_rst_n,
        i_start |-> (r_cnt == '0), "restart mid division")
    `ITRA_ASSERT(a_done_after_last_step, i_clk, i_rst_n,
        (r_cnt == DIV_CNT_W'(1)) |=> r_done, "missing done")

endmodule

// ===== rtl/itra_emitter.sv =====
// digit store and character emitter: reads digits in order, maps them to ascii and
// drives the result channel via an output register; depends on itra_pkg, assert_macros.svh
`include "assert_macros.svh"

module itra_emitter import itra_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_digit_wr  i_wr,
    input  t_emit_cmd  i_cmd,
    output logic       o_busy,
    itra_out_if.source o_out
);

    // digit store
    logic [RADIX_W-1:0] r_digits [DIGIT_DEPTH];

    // latched command
    logic             r_busy;
    logic             r_err;
    logic             r_neg;
    logic             r_upper;
    logic [LEN_W-1:0] r_ndig;
    logic [LEN_W-1:0] r_total;
    logic [LEN_W-1:0] r_slots;
    logic [LEN_W-1:0] r_iss;

    // read stage
    logic               r_rd_vld;
    logic [RADIX_W-1:0] r_rd_digit;
    logic [POS_W-1:0]   r_rd_pos;
    logic               r_rd_sign;
    logic               r_rd_err;

    // output register
    logic              r_out_vld;
    logic [CHAR_W-1:0] r_out_char;
    logic [POS_W-1:0]  r_out_pos;
    logic [LEN_W-1:0]  r_out_total;
    logic              r_out_status;
    logic              r_out_last;

    logic              move;
    logic              issue;
    logic              last_slot;
    logic              slot_sign;
    logic [POS_W-1:0]  slot_pos;
    logic [CHAR_W-1:0] rd_char;

    // stage handshakes and slot decode
    always_comb begin
        move      = r_rd_vld && (!r_out_vld || o_out.ready);
        issue     = r_busy && (!r_rd_vld || move);
        last_slot = (r_iss == r_slots - LEN_W'(1));
        slot_sign = (r_iss >= r_ndig);
        slot_pos  = r_err ? '0 : POS_W'(r_total - LEN_W'(1) - r_iss);
    end

    // character of the item in the read stage
    always_comb begin
        if (r_rd_err) begin
            rd_char = ASCII_NUL;
        end else if (r_rd_sign) begin
            rd_char = r_neg ? ASCII_MINUS : ASCII_PLUS;
        end else begin
            rd_char = digit_char(r_rd_digit, r_upper);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_iss     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_iss  <= '0;
            end else if (issue) begin
                r_iss <= r_iss + LEN_W'(1);
                if (last_slot) begin
                    r_busy <= 1'b0;
                end
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (move) begin
                r_rd_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // digit store, write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_digits[i_wr.addr] <= i_wr.digit;
        end
        if (issue && !slot_sign) begin
            r_rd_digit <= r_digits[r_iss[DIGIT_ADDR_W-1:0]];
        end
    end

    // command, read stage and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_err   <= i_cmd.err;
            r_neg   <= i_cmd.neg;
            r_upper <= i_cmd.upper;
            r_ndig  <= i_cmd.ndig;
            r_total <= i_cmd.total;
            r_slots <= i_cmd.err ? LEN_W'(1) : i_cmd.total;
        end
        if (issue) begin
            r_rd_pos  <= slot_pos;
            r_rd_sign <= slot_sign;
            r_rd_err  <= r_err;
        end
        if (move) begin
            r_out_char   <= rd_char;
            r_out_pos    <= r_rd_pos;
            r_out_total  <= r_rd_err ? '0 : r_total;
            r_out_status <= r_rd_err ? STATUS_TOO_LONG : STATUS_OK;
            r_out_last   <= (r_rd_pos == '0);
        end
    end

    assign o_busy             = r_busy || r_rd_vld;
    assign o_out.valid        = r_out_vld;
    assign o_out.character    = r_out_char;
    assign o_out.position     = r_out_pos;
    assign o_out.total_length = r_out_total;
    assign o_out.status       = r_out_status;
    assign o_out.last         = r_out_last;

    // checks
    `ITRA_ASSERT(a_start_when_free, i_clk, i_rst_n,
        i_cmd.start |-> !o_busy, "emit start while busy")
    `ITRA_NEVER(a_no_write_while_reading, i_clk, i_rst_n,
        i_wr.en && r_busy, "digit write during emission")
    `ITRA_ASSERT(a_error_single_item, i_clk, i_rst_n,
        (r_out_vld && r_out_status) |-> (r_out_last && (r_out_total == '0)),
        "bad error item")

endmodule
